FILE: rtl/swgc_pkg.sv
// ----------------------------------------------------------------------------
// swgc_pkg
// Shared types and constants for the sliding-window GC content block.
// ----------------------------------------------------------------------------
package swgc_pkg;

   localparam int CHAR_W      = 8;
   localparam int LEN_W       = 11;
   localparam int POS_W       = 32;
   localparam int PROD_W      = 2 * LEN_W;
   localparam int NUM_W       = PROD_W + 2;
   localparam int QUO_W       = LEN_W + 1;
   localparam int QCNT_W      = $clog2(QUO_W);
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(200);

   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
   localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_G_UP  = 8'h47;
   localparam logic [CHAR_W-1:0] CH_C_UP  = 8'h43;
   localparam logic [CHAR_W-1:0] CH_N_UP  = 8'h4E;
   localparam logic [CHAR_W-1:0] CH_G_LO  = 8'h67;
   localparam logic [CHAR_W-1:0] CH_C_LO  = 8'h63;
   localparam logic [CHAR_W-1:0] CH_N_LO  = 8'h6E;

   typedef enum logic [1:0] {
      CLS_OTHER = 2'd0,
      CLS_GC    = 2'd1,
      CLS_N     = 2'd2
   } cls_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_UPDATE,
      BK_EVAL,
      BK_MUL,
      BK_DIV
   } back_state_type;

   typedef struct packed {
      logic    valid;
      cls_type cls;
   } front_out_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [QUO_W-1:0] den2;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: rtl/swgc_front.sv
// ----------------------------------------------------------------------------
// swgc_front
// Classifies incoming characters, drops whitespace and queues base classes.
// ----------------------------------------------------------------------------
module swgc_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   input  logic [swgc_pkg::CHAR_W-1:0] req_base_char,
   output logic                        req_full,
   output swgc_pkg::front_out_type     q_out,
   input  logic                        q_pop
);
   import swgc_pkg::*;

   cls_type               q_mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     cnt_ff, cnt_in;
   logic                  is_ws;
   cls_type               cls;
   logic                  push_ok;
   logic                  pop_ok;

   always_comb begin
      is_ws = 1'b0;
      cls   = CLS_OTHER;
      unique case (req_base_char) inside
         CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: is_ws = 1'b1;
         CH_G_UP, CH_C_UP, CH_G_LO, CH_C_LO:           cls = CLS_GC;
         CH_N_UP, CH_N_LO:                             cls = CLS_N;
         default: ;
      endcase
   end

   assign req_full = (cnt_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign push_ok  = req_push && !req_full && !is_ws;
   assign pop_ok   = q_pop && (cnt_ff != '0);

   assign q_out.valid = (cnt_ff != '0);
   assign q_out.cls   = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + (QUEUE_AW+1)'(push_ok) - (QUEUE_AW+1)'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_mem_ff[wr_ptr_ff] <= cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

FILE: rtl/swgc_div.sv
// ----------------------------------------------------------------------------
// swgc_div
// Restoring divider, one quotient bit per cycle, for the GC rescale.
// ----------------------------------------------------------------------------
module swgc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  swgc_pkg::div_req_type div_req,
   output swgc_pkg::div_rsp_type div_rsp
);
   import swgc_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic [NUM_W-1:0]    rem_ff, rem_in;
   logic [NUM_W-1:0]    dvs_ff, dvs_in;
   logic [QUO_W-1:0]    quo_ff, quo_in;
   logic                fits;

   assign fits = (rem_ff >= dvs_ff);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dvs_ff;
         end
         quo_in = {quo_ff[QUO_W-2:0], fits};
         dvs_in = dvs_ff >> 1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end else if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = QCNT_W'(QUO_W - 1);
         rem_in  = div_req.num;
         dvs_in  = NUM_W'(div_req.den2) << (QUO_W - 1);
         quo_in  = '0;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

FILE: rtl/swgc_back.sv
// ----------------------------------------------------------------------------
// swgc_back
// Window ring, running GC/N counts, eligibility and rescale, result register.
// ----------------------------------------------------------------------------
module swgc_back #(
   parameter int WINDOW_MAX = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [swgc_pkg::LEN_W-1:0]  len,
   input  logic                        cfg_we,
   input  swgc_pkg::front_out_type     q_in,
   output logic                        q_pop,
   output swgc_pkg::div_req_type       div_req,
   input  swgc_pkg::div_rsp_type       div_rsp,
   input  logic                        rsp_pop,
   output logic                        rsp_empty,
   output logic [swgc_pkg::POS_W-1:0]  rsp_window_start,
   output logic                        rsp_eligible,
   output logic [swgc_pkg::LEN_W-1:0]  rsp_gc_scaled,
   output logic [swgc_pkg::LEN_W-1:0]  rsp_n_count
);
   import swgc_pkg::*;

   localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int DW = ((AW > LEN_W) ? AW : LEN_W) + 2;

   cls_type          win_mem [WINDOW_MAX];
   cls_type          old_ff;
   logic             mem_we;
   logic             mem_re;
   logic [AW-1:0]    rd_addr;
   logic [DW-1:0]    idx_diff;

   back_state_type   state_ff, state_in;
   logic [AW-1:0]    ring_ff, ring_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0] gc_ff, gc_in;
   logic [LEN_W-1:0] n_ff, n_in;
   logic [LEN_W-1:0] fill_ff, fill_in;
   cls_type          cls_ff, cls_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [LEN_W-1:0] den_ff, den_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0] rsp_ws_ff, rsp_ws_in;
   logic             rsp_elig_ff, rsp_elig_in;
   logic [LEN_W-1:0] rsp_gc_ff, rsp_gc_in;
   logic [LEN_W-1:0] rsp_n_ff, rsp_n_in;

   logic             was_full;
   logic             gc_dec, n_dec;
   logic [LEN_W+2:0] n_times5;

   // oldest slot of the window, modulo the ring depth
   always_comb begin
      idx_diff = DW'(ring_ff) - DW'(len);
      if (DW'(ring_ff) < DW'(len)) begin
         idx_diff = idx_diff + DW'(WINDOW_MAX);
      end
      rd_addr = idx_diff[AW-1:0];
   end

   assign was_full = (fill_ff >= len);
   assign gc_dec   = was_full && (old_ff == CLS_GC) && (gc_ff != '0);
   assign n_dec    = was_full && (old_ff == CLS_N) && (n_ff != '0);
   assign n_times5 = (LEN_W+3)'(n_ff) * (LEN_W+3)'(5);

   always_comb begin
      state_in     = state_ff;
      ring_in      = ring_ff;
      pos_in       = pos_ff;
      gc_in        = gc_ff;
      n_in         = n_ff;
      fill_in      = fill_ff;
      cls_in       = cls_ff;
      prod_in      = prod_ff;
      den_in       = den_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ws_in    = rsp_ws_ff;
      rsp_elig_in  = rsp_elig_ff;
      rsp_gc_in    = rsp_gc_ff;
      rsp_n_in     = rsp_n_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      div_req      = '0;

      if (rsp_pop && rsp_valid_ff) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         BK_IDLE: begin
            if (q_in.valid && !rsp_valid_ff) begin
               q_pop    = 1'b1;
               mem_we   = 1'b1;
               mem_re   = 1'b1;
               cls_in   = q_in.cls;
               ring_in  = (ring_ff == AW'(WINDOW_MAX - 1)) ? '0 : ring_ff + 1'b1;
               pos_in   = pos_ff + 1'b1;
               state_in = BK_UPDATE;
            end
         end
         BK_UPDATE: begin
            fill_in  = was_full ? len : fill_ff + 1'b1;
            gc_in    = gc_ff - LEN_W'(gc_dec) + LEN_W'(cls_ff == CLS_GC);
            n_in     = n_ff - LEN_W'(n_dec) + LEN_W'(cls_ff == CLS_N);
            state_in = (fill_in >= len) ? BK_EVAL : BK_IDLE;
         end
         BK_EVAL: begin
            rsp_ws_in = pos_ff - POS_W'(len);
            rsp_n_in  = n_ff;
            if (n_times5 >= (LEN_W+3)'(len)) begin
               rsp_valid_in = 1'b1;
               rsp_elig_in  = 1'b0;
               rsp_gc_in    = '0;
               state_in     = BK_IDLE;
            end else if (n_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_elig_in  = 1'b1;
               rsp_gc_in    = gc_ff;
               state_in     = BK_IDLE;
            end else begin
               prod_in  = PROD_W'(gc_ff) * PROD_W'(len);
               den_in   = len - n_ff;
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            div_req.start = 1'b1;
            div_req.num   = NUM_W'({prod_ff, 1'b0}) + NUM_W'(den_ff);
            div_req.den2  = {den_ff, 1'b0};
            state_in      = BK_DIV;
         end
         BK_DIV: begin
            if (div_rsp.done) begin
               rsp_valid_in = 1'b1;
               rsp_elig_in  = 1'b1;
               rsp_gc_in    = div_rsp.quotient[LEN_W-1:0];
               state_in     = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase

      // new length restarts the window fill
      if (cfg_we) begin
         fill_in = '0;
         gc_in   = '0;
         n_in    = '0;
      end
   end

   // read-first ring memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         win_mem[ring_ff] <= q_in.cls;
      end
      if (mem_re) begin
         old_ff <= win_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      cls_ff    <= cls_in;
      prod_ff   <= prod_in;
      den_ff    <= den_in;
      rsp_ws_ff <= rsp_ws_in;
      rsp_elig_ff <= rsp_elig_in;
      rsp_gc_ff <= rsp_gc_in;
      rsp_n_ff  <= rsp_n_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         ring_ff      <= '0;
         pos_ff       <= '0;
         gc_ff        <= '0;
         n_ff         <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ring_ff      <= ring_in;
         pos_ff       <= pos_in;
         gc_ff        <= gc_in;
         n_ff         <= n_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_empty        = !rsp_valid_ff;
   assign rsp_window_start = rsp_ws_ff;
   assign rsp_eligible     = rsp_elig_ff;
   assign rsp_gc_scaled    = rsp_gc_ff;
   assign rsp_n_count      = rsp_n_ff;

endmodule

FILE: rtl/sliding_window_gc_content.sv
// ----------------------------------------------------------------------------
// sliding_window_gc_content
// GC and N counts over a sliding window of sequence bases, with N-based
// eligibility and exact rounded rescale of the GC count to the window length.
//
//   channel  ports                          transaction
//   req      req_push / req_full            one sequence character
//   rsp      rsp_empty / rsp_pop            one window result
//   csr      csr_we / csr_wdata             fragment length write
//
// whitespace characters are dropped in the front and never reach the back;
// per base the back runs IDLE and UPDATE while the window fills, adds EVAL once
// it is full, and MUL and DIV when the window holds N bases and the rescale runs
// through the 12-step restoring divider; the back starts a base only once the
// single result register is free, so the next base waits until the result is taken;
// a 4-entry class queue keeps req taking characters meanwhile
// reset is synchronous; no clearing pass, a ring slot's value is only used once written
// ----------------------------------------------------------------------------
module sliding_window_gc_content #(
   parameter int WINDOW_MAX = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   input  logic [swgc_pkg::CHAR_W-1:0] req_base_char,
   output logic                        req_full,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [swgc_pkg::POS_W-1:0]  rsp_window_start,
   output logic                        rsp_eligible,
   output logic [swgc_pkg::LEN_W-1:0]  rsp_gc_scaled,
   output logic [swgc_pkg::LEN_W-1:0]  rsp_n_count,
   input  logic                        csr_we,
   input  logic [swgc_pkg::LEN_W-1:0]  csr_wdata
);
   import swgc_pkg::*;

   logic [LEN_W-1:0] csr_len_ff;
   logic [LEN_W-1:0] len_eff;
   front_out_type    q_out;
   logic             q_pop;
   div_req_type      div_req;
   div_rsp_type      div_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_len_ff <= LEN_RESET;
      end else if (csr_we) begin
         csr_len_ff <= csr_wdata;
      end
   end

   always_comb begin
      len_eff = csr_len_ff;
      if (csr_len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (32'(csr_len_ff) > 32'(WINDOW_MAX)) begin
         len_eff = LEN_W'(WINDOW_MAX);
      end
   end

   swgc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_base_char (req_base_char),
      .req_full      (req_full),
      .q_out         (q_out),
      .q_pop         (q_pop)
   );

   swgc_back #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .len              (len_eff),
      .cfg_we           (csr_we),
      .q_in             (q_out),
      .q_pop            (q_pop),
      .div_req          (div_req),
      .div_rsp          (div_rsp),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_window_start (rsp_window_start),
      .rsp_eligible     (rsp_eligible),
      .rsp_gc_scaled    (rsp_gc_scaled),
      .rsp_n_count      (rsp_n_count)
   );

   swgc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

`ifndef NO_ASSERTIONS
   a_inelig_gc_zero : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_eligible) |-> (rsp_gc_scaled == '0))
      else $error("ineligible window carries a gc value");

   a_gc_within_len : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_eligible) |-> (rsp_gc_scaled <= len_eff))
      else $error("rescaled gc exceeds window length");

   a_elig_n_bound : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_eligible) |->
      ((LEN_W+3)'(rsp_n_count) * (LEN_W+3)'(5) < (LEN_W+3)'(len_eff)))
      else $error("eligible window has too many n bases");

   a_n_within_len : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_n_count <= len_eff))
      else $error("n count exceeds window length");
`endif

endmodule

FILE: verif/tb_sliding_window_gc_content.sv
// ----------------------------------------------------------------------------
// tb_sliding_window_gc_content
// Streams sequence characters into the sliding-window GC counter and checks
// every window result against a cycle-free model of the window counts,
// across several fragment lengths (reset value, zero, one, short windows,
// full and oversize), with sender gaps, receiver stalls and a long hold-off
// of the result side that backs up the input.
// ----------------------------------------------------------------------------
module tb_sliding_window_gc_content;
   timeunit 1ns;
   timeprecision 1ps;

   import swgc_pkg::*;

   localparam int WINDOW_MAX    = 1024;
   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 200;
   localparam int MAX_REPORTS   = 10;
   localparam int HOLD_CYCLES   = 300;
   localparam int RESET_CYCLES  = 12;

   typedef struct packed {
      logic [POS_W-1:0] window_start;
      logic             eligible;
      logic [LEN_W-1:0] gc_scaled;
      logic [LEN_W-1:0] n_count;
   } window_stats_type;

   logic              clock;
   logic              reset;
   logic              req_push;
   logic [CHAR_W-1:0] req_base_char;
   logic              req_full;
   logic              rsp_empty;
   logic              rsp_pop;
   logic [POS_W-1:0]  rsp_window_start;
   logic              rsp_eligible;
   logic [LEN_W-1:0]  rsp_gc_scaled;
   logic [LEN_W-1:0]  rsp_n_count;
   logic              csr_we;
   logic [LEN_W-1:0]  csr_wdata;

   cls_type          ring_cls [WINDOW_MAX];
   logic [LEN_W-1:0] length_reg;
   int unsigned      gc_total;
   int unsigned      n_total;
   int unsigned      fill_count;
   int unsigned      ring_ptr;
   logic [POS_W-1:0] base_pos;
   window_stats_type pending_windows [$];

   int error_count;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_request;

   sliding_window_gc_content #(
      .WINDOW_MAX(WINDOW_MAX)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_base_char   (req_base_char),
      .req_full        (req_full),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_window_start(rsp_window_start),
      .rsp_eligible    (rsp_eligible),
      .rsp_gc_scaled   (rsp_gc_scaled),
      .rsp_n_count     (rsp_n_count),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned window_length();
      int unsigned len;
      len = length_reg;
      if (len == 0) len = 1;
      if (len > WINDOW_MAX) len = WINDOW_MAX;
      return len;
   endfunction

   function automatic bit is_blank(logic [CHAR_W-1:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
             c == CH_FF || c == CH_CR;
   endfunction

   function automatic cls_type base_class(logic [CHAR_W-1:0] c);
      if (c == CH_G_UP || c == CH_C_UP || c == CH_G_LO || c == CH_C_LO) return CLS_GC;
      if (c == CH_N_UP || c == CH_N_LO) return CLS_N;
      return CLS_OTHER;
   endfunction

   function automatic void predict_window(logic [CHAR_W-1:0] c);
      int unsigned      len;
      cls_type          cls;
      cls_type          old;
      longint unsigned  den;
      longint unsigned  num;
      window_stats_type w;
      if (is_blank(c)) return;
      len = window_length();
      cls = base_class(c);
      if (fill_count >= len) begin
         old = ring_cls[(ring_ptr + WINDOW_MAX - len) % WINDOW_MAX];
         if (old == CLS_GC && gc_total > 0) gc_total--;
         if (old == CLS_N && n_total > 0) n_total--;
         fill_count = len;
      end else begin
         fill_count++;
      end
      ring_cls[ring_ptr] = cls;
      ring_ptr = (ring_ptr + 1) % WINDOW_MAX;
      if (cls == CLS_GC) gc_total++;
      if (cls == CLS_N) n_total++;
      base_pos = base_pos + 1'b1;
      if (fill_count < len) return;
      w.window_start = base_pos - POS_W'(len);
      w.eligible     = (5 * n_total) < len;
      w.n_count      = LEN_W'(n_total);
      w.gc_scaled    = '0;
      if (w.eligible) begin
         if (n_total == 0) begin
            w.gc_scaled = LEN_W'(gc_total);
         end else begin
            // exact rounding, halves up
            den = len - n_total;
            num = 2 * longint'(gc_total) * longint'(len) + den;
            w.gc_scaled = LEN_W'(num / (2 * den));
         end
      end
      pending_windows.insert(pending_windows.size(), w);
   endfunction

   function automatic void check_window(window_stats_type got);
      window_stats_type want;
      if (pending_windows.size() == 0) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("unexpected transaction: start=%0d eligible=%0d gc=%0d n=%0d",
                     got.window_start, got.eligible, got.gc_scaled, got.n_count);
         return;
      end
      want = pending_windows.pop_front();
      if (got.window_start !== want.window_start || got.eligible !== want.eligible ||
          got.gc_scaled !== want.gc_scaled || got.n_count !== want.n_count) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("mismatch exp/act: start %0d/%0d eligible %0d/%0d gc %0d/%0d n %0d/%0d",
                     want.window_start, got.window_start, want.eligible, got.eligible,
                     want.gc_scaled, got.gc_scaled, want.n_count, got.n_count);
      end
   endfunction

   function automatic logic [CHAR_W-1:0] random_base(int n_pct, int gc_pct);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 4) return CHAR_W'($urandom_range(0, 255));
      if (r < 8) begin
         case ($urandom_range(0, 5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            3: return CH_VT;
            4: return CH_FF;
            default: return CH_CR;
         endcase
      end
      if (r < 9) return ">";
      if ($urandom_range(0, 99) < n_pct) return $urandom_range(0, 1) ? CH_N_UP : CH_N_LO;
      if ($urandom_range(0, 99) < gc_pct) begin
         case ($urandom_range(0, 3))
            0: return CH_G_UP;
            1: return CH_C_UP;
            2: return CH_G_LO;
            default: return CH_C_LO;
         endcase
      end
      case ($urandom_range(0, 3))
         0: return "A";
         1: return "T";
         2: return "a";
         default: return "t";
      endcase
   endfunction

   task automatic send_base(input logic [CHAR_W-1:0] c);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push      <= 1'b1;
      req_base_char <= c;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_window(c);
   endtask

   task automatic wait_quiet();
      req_push <= 1'b0;
      while (pending_windows.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input logic [LEN_W-1:0] len);
      wait_quiet();
      csr_wdata <= len;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      length_reg = len;
      fill_count = 0;
      gc_total   = 0;
      n_total    = 0;
   endtask

   task automatic send_random(input int count, input int n_pct);
      int gc_pct;
      gc_pct = 50;
      for (int i = 0; i < count; i++) begin
         if (i % 32 == 0) gc_pct = $urandom_range(0, 100);
         send_base(random_base(n_pct, gc_pct));
      end
      wait_quiet();
   endtask

   task automatic test_reset_length();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_random(230, 19);
   endtask

   task automatic test_directed_cases();
      logic [CHAR_W-1:0] seq [21];
      seq = '{"G", "C", "g", "A", "T", "a", "N", "c",
              CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR,
              "n", ">", 8'h00, 8'hFF, "T", "G", "C"};
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      // seven-base window with one n and three gc rounds a half up
      write_length(LEN_W'(7));
      foreach (seq[i]) send_base(seq[i]);
      wait_quiet();
   endtask

   task automatic test_length_zero();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_length(LEN_W'(0));
      send_random(40, 20);
   endtask

   task automatic test_sender_gaps();
      send_idle_pct  = 70;
      recv_stall_pct = 0;
      write_length(LEN_W'(9));
      send_random(150, 12);
   endtask

   task automatic test_receiver_stalls();
      send_idle_pct  = 0;
      recv_stall_pct = 70;
      write_length(LEN_W'(16));
      send_random(150, 12);
   endtask

   task automatic test_both_idle();
      send_idle_pct  = 14;
      recv_stall_pct = 14;
      write_length(LEN_W'(23));
      send_random(150, 15);
   endtask

   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_length(LEN_W'(1));
      hold_request = HOLD_CYCLES;
      send_random(120, 30);
   endtask

   task automatic test_full_window();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_length(LEN_W'(1024));
      send_random(30, 20);
      // oversize length clamps to the largest window
      write_length(LEN_W'(2047));
      send_random(1100, 20);
   endtask

   initial begin : rsp_side
      int               hold_left;
      window_stats_type got;
      hold_left = 0;
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            got.window_start = rsp_window_start;
            got.eligible     = rsp_eligible;
            got.gc_scaled    = rsp_gc_scaled;
            got.n_count      = rsp_n_count;
            check_window(got);
         end
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (reset || hold_left > 0) begin
            if (hold_left > 0) hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet = 0;
         else quiet++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset         <= 1'b1;
      req_push      <= 1'b0;
      req_base_char <= '0;
      csr_we        <= 1'b0;
      csr_wdata     <= '0;
      length_reg = LEN_RESET;
      base_pos   = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_length();
      test_directed_cases();
      test_length_zero();
      test_sender_gaps();
      test_receiver_stalls();
      test_both_idle();
      test_backpressure();
      test_full_window();
      wait_quiet();

      if (error_count == 0 && pending_windows.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/swgc_pkg.sv
rtl/swgc_front.sv
rtl/swgc_div.sv
rtl/swgc_back.sv
rtl/sliding_window_gc_content.sv
verif/tb_sliding_window_gc_content.sv
